// ===== hw/rtl/lcps_pkg.sv =====
`timescale 1ns / 1ps

package lcps_pkg;

  // Fixed sizes of the pattern tables
  localparam int NUM_CHASES   = 10;
  localparam int NUM_SIGNALS  = 9;
  localparam int SIGNAL_WORDS = 32;
  localparam int CHASE_ROWS   = 16;
  localparam int CHASE_MAXLEN = 12;
  localparam int SIGNAL_ROWS  = 15;
  localparam int ROW_WORDS    = 32;

  // Default depth of the command queue between front and back
  localparam int QUEUE_DEPTH = 2;

  localparam logic [15:0] SIG_ONESHOT         = 16'hfffe;
  localparam logic [15:0] SIG_END             = 16'hffff;
  localparam logic [15:0] TICK_INTERVAL_RESET = 16'd20;

  // Function codes on the input stream
  typedef enum logic [2:0] {
    FUNC_TICK     = 3'd0,
    FUNC_ON       = 3'd1,
    FUNC_OFF      = 3'd2,
    FUNC_RUN      = 3'd3,
    FUNC_CHASE    = 3'd4,
    FUNC_SIGNAL   = 3'd5,
    FUNC_HOLD_SET = 3'd6,
    FUNC_HOLD_CLR = 3'd7
  } func_t;

  // Decoded commands handed from front to back
  typedef enum logic [3:0] {
    CMD_TICK,
    CMD_LIGHTS_ON,
    CMD_LIGHTS_OFF,
    CMD_HALT,
    CMD_CHASE_SEL,
    CMD_SIG_START,
    CMD_SIG_CANCEL,
    CMD_HOLD_SET,
    CMD_HOLD_CLR
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [7:0]  arg;      // halt flag, chase number, signal row or pattern byte
    logic        oneshot;  // signal row runs once
  } cmd_t;

  localparam logic [3:0] CHASE_LEN [CHASE_ROWS] = '{
    0: 4'd6, 1: 4'd10, 2: 4'd11, 3: 4'd4, 4: 4'd6,
    5: 4'd5, 6: 4'd6, 7: 4'd10, 8: 4'd3, 9: 4'd6,
    default: 4'd0
  };

  localparam logic [7:0] CHASE_ROM [CHASE_ROWS][CHASE_MAXLEN] = '{
    0: '{0: 8'h20, 1: 8'h10, 2: 8'h08, 3: 8'h04, 4: 8'h02, 5: 8'h01, default: 8'h00},
    1: '{0: 8'h20, 1: 8'h10, 2: 8'h08, 3: 8'h04, 4: 8'h02, 5: 8'h01,
         6: 8'h02, 7: 8'h04, 8: 8'h08, 9: 8'h10, default: 8'h00},
    2: '{0: 8'h20, 1: 8'h30, 2: 8'h38, 3: 8'h3c, 4: 8'h3e, 5: 8'h3f,
         6: 8'h1f, 7: 8'h0f, 8: 8'h07, 9: 8'h03, 10: 8'h01, default: 8'h00},
    3: '{0: 8'h0c, 1: 8'h12, 2: 8'h21, 3: 8'h12, default: 8'h00},
    4: '{0: 8'h00, 1: 8'h0c, 2: 8'h1e, 3: 8'h3f, 4: 8'h1e, 5: 8'h0c, default: 8'h00},
    5: '{0: 8'h0c, 1: 8'h1e, 2: 8'h3f, 3: 8'h33, 4: 8'h21, default: 8'h00},
    6: '{0: 8'h01, 1: 8'h02, 2: 8'h04, 3: 8'h08, 4: 8'h10, 5: 8'h20, default: 8'h00},
    7: '{0: 8'h01, 1: 8'h20, 2: 8'h02, 3: 8'h10, 4: 8'h04, 5: 8'h08,
         6: 8'h04, 7: 8'h10, 8: 8'h02, 9: 8'h20, default: 8'h00},
    8: '{0: 8'h24, 1: 8'h12, 2: 8'h09, default: 8'h00},
    9: '{0: 8'h30, 1: 8'h18, 2: 8'h0c, 3: 8'h06, 4: 8'h03, 5: 8'h21, default: 8'h00},
    default: '{default: 8'h00}
  };

  // Signal rows: mode word, then (pattern, duration) pairs, then end marker
  localparam logic [15:0] SIGNAL_ROM [SIGNAL_ROWS][ROW_WORDS] = '{
    0: '{0: 16'hfffe, 1: 16'h20, 2: 16'd20, 3: 16'h30, 4: 16'd20, 5: 16'h38, 6: 16'd20,
         7: 16'h3c, 8: 16'd20, 9: 16'h3e, 10: 16'd20, 11: 16'h3f, 12: 16'd40,
         13: 16'h3e, 14: 16'd20, 15: 16'h3c, 16: 16'd20, 17: 16'h38, 18: 16'd20,
         19: 16'h30, 20: 16'd20, 21: 16'h20, 22: 16'd20, 23: 16'hffff,
         default: 16'h0000},
    1: '{0: 16'hfffe, 1: 16'h00, 2: 16'd100, 3: 16'h01, 4: 16'd100, 5: 16'h00,
         6: 16'd100, 7: 16'h01, 8: 16'd100, 9: 16'h00, 10: 16'd100, 11: 16'hffff,
         default: 16'h0000},
    2: '{0: 16'h0000, 1: 16'h20, 2: 16'd50, 3: 16'h01, 4: 16'd50, 5: 16'hffff,
         default: 16'h0000},
    3: '{0: 16'hfffe, 1: 16'h00, 2: 16'd100, 3: 16'h20, 4: 16'd100, 5: 16'h00,
         6: 16'd100, 7: 16'h20, 8: 16'd100, 9: 16'h00, 10: 16'd100, 11: 16'hffff,
         default: 16'h0000},
    4: '{0: 16'hfffe, 1: 16'h07, 2: 16'd50, 3: 16'h38, 4: 16'd50, 5: 16'h07, 6: 16'd50,
         7: 16'h38, 8: 16'd50, 9: 16'h07, 10: 16'd50, 11: 16'h38, 12: 16'd50,
         13: 16'h07, 14: 16'd50, 15: 16'h38, 16: 16'd50, 17: 16'h00, 18: 16'd1,
         19: 16'hffff, default: 16'h0000},
    5: '{0: 16'hfffe, 1: 16'h00, 2: 16'd20, 3: 16'h3f, 4: 16'd100, 5: 16'h00,
         6: 16'd100, 7: 16'h3f, 8: 16'd100, 9: 16'h00, 10: 16'd1, 11: 16'hffff,
         default: 16'h0000},
    6: '{0: 16'hfffe, 1: 16'h00, 2: 16'd10, 3: 16'h0c, 4: 16'd50, 5: 16'h00,
         6: 16'd50, 7: 16'h0c, 8: 16'd50, 9: 16'h00, 10: 16'd1, 11: 16'hffff,
         default: 16'h0000},
    7: '{0: 16'hfffe, 1: 16'h00, 2: 16'd10, 3: 16'h3f, 4: 16'd50, 5: 16'h00,
         6: 16'd50, 7: 16'h3f, 8: 16'd50, 9: 16'h00, 10: 16'd50, 11: 16'hffff,
         default: 16'h0000},
    8: '{0: 16'h0000, 1: 16'h30, 2: 16'd20, 3: 16'h03, 4: 16'd20, 5: 16'hffff,
         default: 16'h0000},
    default: '{default: 16'h0000}
  };

  // Signal word lookup; rows and positions off the table read as the end marker
  function automatic logic [15:0] sig_word(input logic [3:0] num, input logic [5:0] pos);
    logic [15:0] w;
    w = SIG_END;
    if (num < 4'(SIGNAL_ROWS) && pos < 6'(SIGNAL_WORDS) && pos < 6'(ROW_WORDS)) begin
      w = SIGNAL_ROM[num][pos[4:0]];
    end
    return w;
  endfunction

  function automatic logic [3:0] chase_len_of(input logic [3:0] choice);
    logic [3:0] n;
    n = CHASE_LEN[choice];
    if (n > 4'(CHASE_MAXLEN)) begin
      n = 4'(CHASE_MAXLEN);
    end
    return n;
  endfunction

  function automatic logic [7:0] chase_pat(input logic [3:0] choice, input logic [3:0] step);
    logic [7:0] p;
    p = 8'h00;
    if (step < 4'(CHASE_MAXLEN)) begin
      p = CHASE_ROM[choice][step];
    end
    return p;
  endfunction

endpackage

// ===== hw/rtl/led_chase_pattern_sequencer_top.sv =====
// LED chase sequencer: one result per request, in request order.
// Requests pass through the command queue, then the back end's result register.
// Throughput: one request and one executed command per cycle unless the output stalls.
// A stalled output fills the command queue, then holds s_axis_tready low.
// Reset (rst, synchronous, active high) clears the queue, sequencer state and
// output valid; tick_interval returns to 20.
`timescale 1ns / 1ps

module led_chase_pattern_sequencer_top #(
  parameter int FIFO_DEPTH = lcps_pkg::QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // value[7:0]
  input  logic [2:0]  s_axis_tuser,   // func[2:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // update_valid, pattern[7:0], special_done, zero pad
  input  logic        cfg_wr_en,
  input  logic [15:0] cfg_wr_data     // tick_interval
);
  import lcps_pkg::*;

  logic q_push;
  logic q_full;
  logic q_pop;
  logic q_empty;
  cmd_t q_in;
  cmd_t q_out;

  // front: accept and decode
  lcps_front u_front (
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .q_full        (q_full),
    .q_push        (q_push),
    .q_cmd         (q_in)
  );

  // command queue
  lcps_queue #(
    .DEPTH (FIFO_DEPTH)
  ) u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_in),
    .full     (q_full),
    .pop      (q_pop),
    .empty    (q_empty),
    .pop_cmd  (q_out)
  );

  // back: sequencer state and result register
  lcps_back u_back (
    .clk           (clk),
    .rst           (rst),
    .cmd_avail     (!q_empty),
    .cmd           (q_out),
    .cmd_pop       (q_pop),
    .cfg_wr_en     (cfg_wr_en),
    .cfg_wr_data   (cfg_wr_data),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

endmodule

// ===== hw/rtl/lcps_front.sv =====
`timescale 1ns / 1ps

module lcps_front (
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,   // value
  input  logic [2:0]          s_axis_tuser,   // func
  input  logic                q_full,
  output logic                q_push,
  output lcps_pkg::cmd_t      q_cmd
);
  import lcps_pkg::*;

  logic [7:0] value_m1;

  // take a request whenever the queue has room
  assign s_axis_tready = !q_full;
  assign q_push        = s_axis_tvalid && !q_full;
  assign value_m1      = s_axis_tdata - 8'd1;

  // classify the request and resolve its operand
  always_comb begin
    q_cmd.kind    = CMD_TICK;
    q_cmd.arg     = 8'h00;
    q_cmd.oneshot = 1'b0;
    case (func_t'(s_axis_tuser))
      FUNC_TICK: q_cmd.kind = CMD_TICK;
      FUNC_ON:   q_cmd.kind = CMD_LIGHTS_ON;
      FUNC_OFF:  q_cmd.kind = CMD_LIGHTS_OFF;
      FUNC_RUN: begin
        q_cmd.kind = CMD_HALT;
        q_cmd.arg  = {7'd0, |s_axis_tdata};
      end
      FUNC_CHASE: begin
        q_cmd.kind = CMD_CHASE_SEL;
        q_cmd.arg  = (s_axis_tdata >= 8'(NUM_CHASES)) ? 8'h00 : s_axis_tdata;
      end
      FUNC_SIGNAL: begin
        if (s_axis_tdata != 8'h00 && s_axis_tdata <= 8'(NUM_SIGNALS)) begin
          q_cmd.kind    = CMD_SIG_START;
          q_cmd.arg     = {4'd0, value_m1[3:0]};
          q_cmd.oneshot = (sig_word(value_m1[3:0], 6'd0) == SIG_ONESHOT);
        end else begin
          q_cmd.kind = CMD_SIG_CANCEL;
        end
      end
      FUNC_HOLD_SET: begin
        q_cmd.kind = CMD_HOLD_SET;
        q_cmd.arg  = s_axis_tdata;
      end
      FUNC_HOLD_CLR: q_cmd.kind = CMD_HOLD_CLR;
      default:       q_cmd.kind = CMD_HOLD_CLR;
    endcase
  end

endmodule

// ===== hw/rtl/lcps_queue.sv =====
`timescale 1ns / 1ps

module lcps_queue #(
  parameter int DEPTH = lcps_pkg::QUEUE_DEPTH
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  lcps_pkg::cmd_t      push_cmd,
  output logic                full,
  input  logic                pop,
  output logic                empty,
  output lcps_pkg::cmd_t      pop_cmd
);
  import lcps_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  cmd_t             slots [DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;

  assign full    = (count == CNT_W'(DEPTH));
  assign empty   = (count == '0);
  assign pop_cmd = slots[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + PTR_W'(1);
      end
      if (push && !pop) begin
        count <= count + CNT_W'(1);
      end else if (pop && !push) begin
        count <= count - CNT_W'(1);
      end
    end
  end

endmodule

// ===== hw/rtl/lcps_back.sv =====
`timescale 1ns / 1ps

module lcps_back (
  input  logic                clk,
  input  logic                rst,
  input  logic                cmd_avail,
  input  lcps_pkg::cmd_t      cmd,
  output logic                cmd_pop,
  input  logic                cfg_wr_en,
  input  logic [15:0]         cfg_wr_data,
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [15:0]         m_axis_tdata    // update_valid, pattern[7:0], special_done
);
  import lcps_pkg::*;

  // sequencer state
  logic        signal_active, signal_active_next;
  logic        signal_oneshot, signal_oneshot_next;
  logic [3:0]  signal_number, signal_number_next;
  logic [4:0]  signal_position, signal_position_next;
  logic [15:0] signal_tick_count, signal_tick_count_next;
  logic        signal_was_shown, signal_was_shown_next;
  logic        hold_active, hold_active_next;
  logic        hold_pending, hold_pending_next;
  logic [7:0]  hold_last, hold_last_next;
  logic [7:0]  hold_pattern, hold_pattern_next;
  logic        lights_off_request, lights_off_request_next;
  logic        lights_are_dark, lights_are_dark_next;
  logic        chase_halted, chase_halted_next;
  logic [3:0]  chase_choice, chase_choice_next;
  logic [15:0] chase_tick_count, chase_tick_count_next;
  logic [3:0]  chase_step, chase_step_next;
  logic [15:0] tick_interval;

  // working values of one tick
  logic        wrote;
  logic [7:0]  pat;
  logic        sig_live;
  logic [4:0]  sig_pos_eff;
  logic [15:0] sig_cur_word;
  logic [15:0] sig_show_word;
  logic [15:0] sig_dur;
  logic [15:0] sig_tc_inc;
  logic [15:0] chase_tc_base;
  logic [3:0]  chase_step_base;
  logic [3:0]  chase_len;
  logic [15:0] chase_tc_inc;
  logic [4:0]  chase_step_inc;

  // one command per cycle while the output register is free or draining
  assign cmd_pop = cmd_avail && (!m_axis_tvalid || m_axis_tready);

  // signal table reads
  assign sig_cur_word  = sig_word(signal_number, {1'b0, signal_position});
  assign sig_show_word = sig_word(signal_number, {1'b0, sig_pos_eff});
  assign sig_dur       = sig_word(signal_number, {1'b0, sig_pos_eff} + 6'd1);
  assign sig_tc_inc    = signal_tick_count + 16'd1;

  assign chase_len      = chase_len_of(chase_choice);
  assign chase_tc_inc   = chase_tc_base + 16'd1;
  assign chase_step_inc = {1'b0, chase_step_base} + 5'd1;

  // command execution
  always_comb begin
    signal_active_next      = signal_active;
    signal_oneshot_next     = signal_oneshot;
    signal_number_next      = signal_number;
    signal_position_next    = signal_position;
    signal_tick_count_next  = signal_tick_count;
    signal_was_shown_next   = signal_was_shown;
    hold_active_next        = hold_active;
    hold_pending_next       = hold_pending;
    hold_last_next          = hold_last;
    hold_pattern_next       = hold_pattern;
    lights_off_request_next = lights_off_request;
    lights_are_dark_next    = lights_are_dark;
    chase_halted_next       = chase_halted;
    chase_choice_next       = chase_choice;
    chase_tick_count_next   = chase_tick_count;
    chase_step_next         = chase_step;
    wrote                   = 1'b0;
    pat                     = 8'h00;
    sig_live                = signal_active;
    sig_pos_eff             = signal_position;
    chase_tc_base           = chase_tick_count;
    chase_step_base         = chase_step;
    if (signal_active && signal_tick_count == 16'd0 && sig_cur_word == SIG_END) begin
      if (signal_oneshot) begin
        sig_live = 1'b0;
      end else begin
        sig_pos_eff = 5'd1;
      end
    end
    if (!signal_active && !hold_active && !lights_off_request && lights_are_dark) begin
      chase_tc_base   = 16'd0;
      chase_step_base = 4'd0;
    end

    case (cmd.kind)
      CMD_TICK: begin
        if (signal_active) begin
          // signal sequence owns the LEDs
          if (signal_tick_count == 16'd0) begin
            signal_was_shown_next = 1'b1;
            if (sig_live) begin
              pat   = sig_show_word[7:0];
              wrote = 1'b1;
            end else begin
              chase_tick_count_next = 16'd0;
              chase_step_next       = 4'd0;
            end
          end
          signal_active_next = sig_live;
          if (sig_live) begin
            if (sig_tc_inc >= sig_dur) begin
              signal_tick_count_next = 16'd0;
              signal_position_next   = sig_pos_eff + 5'd2;
            end else begin
              signal_tick_count_next = sig_tc_inc;
              signal_position_next   = sig_pos_eff;
            end
          end
        end else if (hold_active) begin
          // held pattern, written again only when changed or re-set
          if (hold_pending || hold_last != hold_pattern) begin
            pat               = hold_pattern;
            wrote             = 1'b1;
            hold_last_next    = hold_pattern;
            hold_pending_next = 1'b0;
          end
        end else if (lights_off_request) begin
          if (!lights_are_dark || signal_was_shown) begin
            wrote                 = 1'b1;
            lights_are_dark_next  = 1'b1;
            signal_was_shown_next = 1'b0;
          end
        end else begin
          // chase; restarts from its first step after darkness
          lights_are_dark_next  = 1'b0;
          chase_tick_count_next = chase_tc_base;
          chase_step_next       = chase_step_base;
          if (!chase_halted) begin
            if (chase_tc_base == 16'd0) begin
              wrote = 1'b1;
              if (chase_len != 4'd0 && chase_step_base < chase_len) begin
                pat = chase_pat(chase_choice, chase_step_base);
              end
            end
            if (chase_len != 4'd0) begin
              if (chase_tc_inc >= tick_interval) begin
                chase_tick_count_next = 16'd0;
                chase_step_next = (chase_step_inc >= {1'b0, chase_len}) ?
                                  4'd0 : chase_step_inc[3:0];
              end else begin
                chase_tick_count_next = chase_tc_inc;
              end
            end
          end
        end
      end
      CMD_LIGHTS_ON:  lights_off_request_next = 1'b0;
      CMD_LIGHTS_OFF: lights_off_request_next = 1'b1;
      CMD_HALT:       chase_halted_next = cmd.arg[0];
      CMD_CHASE_SEL: begin
        chase_choice_next     = cmd.arg[3:0];
        chase_tick_count_next = 16'd0;
        chase_step_next       = 4'd0;
      end
      CMD_SIG_START: begin
        lights_are_dark_next   = 1'b0;
        signal_active_next     = 1'b1;
        signal_number_next     = cmd.arg[3:0];
        signal_oneshot_next    = cmd.oneshot;
        signal_position_next   = 5'd1;
        signal_tick_count_next = 16'd0;
      end
      CMD_SIG_CANCEL: begin
        lights_are_dark_next = 1'b0;
        signal_active_next   = 1'b0;
      end
      CMD_HOLD_SET: begin
        hold_active_next  = 1'b1;
        hold_pattern_next = cmd.arg;
        hold_pending_next = 1'b1;
      end
      CMD_HOLD_CLR: begin
        hold_active_next  = 1'b0;
        hold_pending_next = 1'b1;
      end
      default: begin
        hold_active_next = hold_active;
      end
    endcase
  end

  // state registers and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      signal_active      <= 1'b0;
      signal_oneshot     <= 1'b0;
      signal_number      <= 4'd0;
      signal_position    <= 5'd0;
      signal_tick_count  <= 16'd0;
      signal_was_shown   <= 1'b0;
      hold_active        <= 1'b0;
      hold_pending       <= 1'b0;
      hold_last          <= 8'h00;
      hold_pattern       <= 8'h00;
      lights_off_request <= 1'b1;
      lights_are_dark    <= 1'b0;
      chase_halted       <= 1'b0;
      chase_choice       <= 4'd0;
      chase_tick_count   <= 16'd0;
      chase_step         <= 4'd0;
      tick_interval      <= TICK_INTERVAL_RESET;
      m_axis_tvalid      <= 1'b0;
      m_axis_tdata       <= 16'h0000;
    end else begin
      if (cfg_wr_en) begin
        tick_interval <= (cfg_wr_data == 16'd0) ? 16'd1 : cfg_wr_data;
      end
      if (cmd_pop) begin
        signal_active      <= signal_active_next;
        signal_oneshot     <= signal_oneshot_next;
        signal_number      <= signal_number_next;
        signal_position    <= signal_position_next;
        signal_tick_count  <= signal_tick_count_next;
        signal_was_shown   <= signal_was_shown_next;
        hold_active        <= hold_active_next;
        hold_pending       <= hold_pending_next;
        hold_last          <= hold_last_next;
        hold_pattern       <= hold_pattern_next;
        lights_off_request <= lights_off_request_next;
        lights_are_dark    <= lights_are_dark_next;
        chase_halted       <= chase_halted_next;
        chase_choice       <= chase_choice_next;
        chase_tick_count   <= chase_tick_count_next;
        chase_step         <= chase_step_next;
        m_axis_tvalid      <= 1'b1;
        m_axis_tdata       <= {6'd0, !signal_active_next, pat, wrote};
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

endmodule

// ===== hw/rtl/lcps_checker.sv =====
`timescale 1ns / 1ps

module lcps_checker (
  input logic        clk,
  input logic        rst,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic [7:0]  s_axis_tdata,
  input logic [2:0]  s_axis_tuser,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [15:0] m_axis_tdata,
  input logic        cfg_wr_en,
  input logic [15:0] cfg_wr_data
);

  // no write to the LEDs means a zero pattern
  a_quiet_pattern: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[8:1] == 8'h00)
    else $error("pattern nonzero without update");

  // pad bits stay clear
  a_pad_zero: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> m_axis_tdata[15:10] == 6'd0)
    else $error("tdata pad bits set");

  // nothing is offered in the cycle after reset
  a_reset_quiet: assert property (@(posedge clk)
    $past(rst) |-> !m_axis_tvalid)
    else $error("result valid straight after reset");

  // a stalled result holds
  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("stalled result changed");

endmodule

bind led_chase_pattern_sequencer_top lcps_checker u_checker (.*);
